// File: sv/i2cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit sequencer package
// Field widths, command codes and shared types for the bit sequencer.
// ----------------------------------------------------------------------------
package i2cbs_pkg;

  localparam int unsigned FuncW    = 3;
  localparam int unsigned AddrW    = 7;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TicksW   = 8;
  localparam int unsigned StepW    = 5;

  localparam logic [FuncW-1:0] FUNC_NONE  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_START = 3'd1;
  localparam logic [FuncW-1:0] FUNC_WRITE = 3'd2;
  localparam logic [FuncW-1:0] FUNC_READ  = 3'd3;
  localparam logic [FuncW-1:0] FUNC_STOP  = 3'd4;

  localparam logic [TicksW-1:0] PHASE_TICKS_RST = 8'd1;

  // Number of phases in each sequence.
  localparam logic [StepW-1:0] LEN_START = 5'd23;
  localparam logic [StepW-1:0] LEN_BYTE  = 5'd19;
  localparam logic [StepW-1:0] LEN_STOP  = 5'd4;
  // Phases below this index belong to the eight data bits of a byte.
  localparam logic [StepW-1:0] BIT_PHASES = 5'd16;
  localparam logic [StepW-1:0] ACK_PHASE  = 5'd16;
  localparam logic [StepW-1:0] ACK_HIGH   = 5'd17;
  localparam logic [StepW-1:0] START_HDR  = 5'd4;

  typedef enum logic [4:0] {
    CMD_IDLE  = 5'b00001,
    CMD_START = 5'b00010,
    CMD_WRITE = 5'b00100,
    CMD_READ  = 5'b01000,
    CMD_STOP  = 5'b10000
  } cmd_e;

  typedef struct packed {
    logic             scl_out;
    logic             sda_out;
    logic             busy_res;
    logic [ByteW-1:0] rd_data;
    logic             rd_valid;
    logic             cmd_rejected;
  } res_t;

endpackage

// File: sv/i2cbs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C bit sequencer channels
// Tick input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface i2cbs_in_if;
  logic                        valid;
  logic                        ready;
  logic [i2cbs_pkg::FuncW-1:0] func;
  logic [i2cbs_pkg::AddrW-1:0] dev_addr;
  logic                        rw_bit;
  logic [i2cbs_pkg::ByteW-1:0] wr_data;
  logic                        send_ack;
  logic                        sda_in;

  modport source (output valid, func, dev_addr, rw_bit, wr_data, send_ack, sda_in,
                  input ready);
  modport sink (input valid, func, dev_addr, rw_bit, wr_data, send_ack, sda_in,
                output ready);
endinterface

interface i2cbs_out_if;
  logic                        valid;
  logic                        ready;
  logic                        scl_out;
  logic                        sda_out;
  logic                        busy_res;
  logic [i2cbs_pkg::ByteW-1:0] rd_data;
  logic                        rd_valid;
  logic                        cmd_rejected;

  modport source (output valid, scl_out, sda_out, busy_res, rd_data, rd_valid,
                  cmd_rejected, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, rd_data, rd_valid,
                cmd_rejected, output ready);
endinterface

interface i2cbs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [i2cbs_pkg::TicksW-1:0] phase_ticks;

  modport source (output valid, phase_ticks, input ready);
  modport sink (input valid, phase_ticks, output ready);
endinterface

// File: sv/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Drives SCL and SDA phase by phase for start, write, read and stop commands.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one timing tick per transfer: the sampled SDA level and,
//   while the sequencer is idle, a command with its operands. Every accepted
//   tick yields exactly one result on res_o with the driven SCL/SDA levels,
//   the busy flag, a completed read byte and a rejected-command flag.
//   cfg_i writes phase_ticks, the number of ticks each phase is held; it is
//   always ready and should only be written while the sequencer is idle.
//   The result of an accepted tick is registered before it is offered.
//   Throughput is one tick per cycle while cmd_i.ready is high, set by the
//   single registered update of the sequencer state. Results pass through a
//   two-entry output buffer, so a tick is still taken while one result waits;
//   cmd_i.ready drops only when both entries are held by a stalled receiver.
//   Reset leaves the bus idle with SCL low, SDA released, phase_ticks of one
//   and the output buffer empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input logic        clk_i,
  input logic        rst_ni,
  i2cbs_in_if.sink   cmd_i,
  i2cbs_cfg_if.sink  cfg_i,
  i2cbs_out_if.source res_o
);
  import i2cbs_pkg::*;

  // Sequencer state.
  cmd_e              cmd_q, cmd_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [ByteW-1:0]  shift_q, shift_d;
  logic [TicksW-1:0] hold_q, hold_d;
  logic              scl_q, scl_d;
  logic              sda_q, sda_d;
  logic              ack_q, ack_d;
  logic [TicksW-1:0] ticks_q;

  // Output buffer.
  res_t              buf_q [2];
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;

  logic              in_fire, out_fire;
  cmd_e              func_cmd;
  logic              is_cmd;
  logic [TicksW-1:0] limit;
  logic [TicksW:0]   held;
  logic [StepW-1:0]  step_next;
  logic              rejected, rd_valid;
  res_t              res;

  function automatic logic [StepW-1:0] seq_len(cmd_e c);
    logic [StepW-1:0] len;
    unique case (c)
      CMD_START:           len = LEN_START;
      CMD_WRITE, CMD_READ: len = LEN_BYTE;
      CMD_STOP:            len = LEN_STOP;
      default:             len = '0;
    endcase
    return len;
  endfunction

  // Returns {scl, sda} after the given phase is applied.
  function automatic logic [1:0] byte_out(logic [StepW-1:0] k, logic [ByteW-1:0] sb,
                                          logic scl, logic sda);
    logic [1:0] lv;
    lv = {scl, sda};
    if (k < BIT_PHASES) begin
      lv = {k[0], sb[~k[3:1]]};
    end else if (k == ACK_PHASE) begin
      lv = 2'b01;
    end else if (k == ACK_HIGH) begin
      lv[1] = 1'b1;
    end else begin
      lv[1] = 1'b0;
    end
    return lv;
  endfunction

  function automatic logic [1:0] byte_in(logic [StepW-1:0] k, logic ack,
                                         logic scl, logic sda);
    logic [1:0] lv;
    lv = {scl, sda};
    if (k < BIT_PHASES) begin
      lv = {~k[0], 1'b1};
    end else if (k == ACK_PHASE) begin
      lv = {1'b0, ~ack};
    end else if (k == ACK_HIGH) begin
      lv[1] = 1'b1;
    end else begin
      lv[1] = 1'b0;
    end
    return lv;
  endfunction

  function automatic logic [1:0] apply_phase(cmd_e c, logic [StepW-1:0] k,
                                             logic [ByteW-1:0] sb, logic ack,
                                             logic scl, logic sda);
    logic [1:0] lv;
    lv = {scl, sda};
    unique case (c)
      CMD_START: begin
        case (k)
          5'd0:    lv[0] = 1'b1;
          5'd1:    lv[1] = 1'b1;
          5'd2:    lv[0] = 1'b0;
          5'd3:    lv[1] = 1'b0;
          default: lv = byte_out(k - START_HDR, sb, scl, sda);
        endcase
      end
      CMD_WRITE: lv = byte_out(k, sb, scl, sda);
      CMD_READ:  lv = byte_in(k, ack, scl, sda);
      CMD_STOP: begin
        case (k)
          5'd0:    lv[1] = 1'b0;
          5'd1:    lv[0] = 1'b0;
          5'd2:    lv[1] = 1'b1;
          default: lv[0] = 1'b1;
        endcase
      end
      default: lv = {scl, sda};
    endcase
    return lv;
  endfunction

  assign cmd_i.ready = (count_q != 2'd2);
  assign in_fire     = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;
  assign out_fire    = res_o.valid && res_o.ready;

  always_comb begin
    unique case (cmd_i.func)
      FUNC_START: func_cmd = CMD_START;
      FUNC_WRITE: func_cmd = CMD_WRITE;
      FUNC_READ:  func_cmd = CMD_READ;
      FUNC_STOP:  func_cmd = CMD_STOP;
      default:    func_cmd = CMD_IDLE;
    endcase
  end

  assign is_cmd    = (func_cmd != CMD_IDLE);
  // A zero hold count behaves as one.
  assign limit     = (ticks_q == '0) ? 8'd1 : ticks_q;
  assign held      = {1'b0, hold_q} + 9'd1;
  assign step_next = step_q + 5'd1;

  always_comb begin
    cmd_d    = cmd_q;
    step_d   = step_q;
    shift_d  = shift_q;
    hold_d   = hold_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    ack_d    = ack_q;
    rejected = 1'b0;
    rd_valid = 1'b0;
    if (cmd_q != CMD_IDLE) begin
      rejected = is_cmd;
      if (held >= {1'b0, limit}) begin
        hold_d = '0;
        // In a read, the end of each SCL-high data phase samples the line.
        if (cmd_q == CMD_READ && step_q < BIT_PHASES && !step_q[0]) begin
          shift_d = {shift_q[ByteW-2:0], cmd_i.sda_in};
        end
        if (step_next >= seq_len(cmd_q)) begin
          if (cmd_q == CMD_READ) begin
            rd_valid = 1'b1;
            sda_d    = 1'b1;
          end
          cmd_d  = CMD_IDLE;
          step_d = '0;
        end else begin
          step_d         = step_next;
          {scl_d, sda_d} = apply_phase(cmd_q, step_next, shift_d, ack_q, scl_q, sda_q);
        end
      end else begin
        hold_d = held[TicksW-1:0];
      end
    end else if (is_cmd) begin
      cmd_d  = func_cmd;
      step_d = '0;
      hold_d = '0;
      unique case (func_cmd)
        CMD_START: shift_d = {cmd_i.dev_addr, cmd_i.rw_bit};
        CMD_WRITE: shift_d = cmd_i.wr_data;
        CMD_READ: begin
          shift_d = '0;
          ack_d   = cmd_i.send_ack;
        end
        default: shift_d = shift_q;
      endcase
      {scl_d, sda_d} = apply_phase(func_cmd, '0, shift_d, ack_d, scl_q, sda_q);
    end
  end

  always_comb begin
    res.scl_out      = scl_d;
    res.sda_out      = sda_d;
    res.busy_res     = (cmd_d != CMD_IDLE);
    res.rd_data      = rd_valid ? shift_d : '0;
    res.rd_valid     = rd_valid;
    res.cmd_rejected = rejected;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q   <= CMD_IDLE;
      step_q  <= '0;
      shift_q <= '0;
      hold_q  <= '0;
      scl_q   <= 1'b0;
      sda_q   <= 1'b1;
      ack_q   <= 1'b0;
    end else if (in_fire) begin
      cmd_q   <= cmd_d;
      step_q  <= step_d;
      shift_q <= shift_d;
      hold_q  <= hold_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      ack_q   <= ack_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= PHASE_TICKS_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      ticks_q <= cfg_i.phase_ticks;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (out_fire) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (in_fire && !out_fire) begin
        count_q <= count_q + 2'd1;
      end else if (!in_fire && out_fire) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assign res_o.valid        = (count_q != '0);
  assign res_o.scl_out      = buf_q[rd_ptr_q].scl_out;
  assign res_o.sda_out      = buf_q[rd_ptr_q].sda_out;
  assign res_o.busy_res     = buf_q[rd_ptr_q].busy_res;
  assign res_o.rd_data      = buf_q[rd_ptr_q].rd_data;
  assign res_o.rd_valid     = buf_q[rd_ptr_q].rd_valid;
  assign res_o.cmd_rejected = buf_q[rd_ptr_q].cmd_rejected;

endmodule
